// ----- rtl/core/vtp_pkg.sv -----
// Shared types and constants for the vertex projection pipeline.
// No dependencies.
package vtp_pkg;

  typedef struct packed {
    logic signed [7:0] vertex_x;
    logic signed [7:0] vertex_y;
    logic signed [7:0] vertex_z;
  } vtx_t;

  typedef struct packed {
    logic signed [19:0] screen_x;
    logic signed [19:0] screen_y;
    logic signed [23:0] depth;
    logic               behind_viewer;
  } scr_t;

  localparam logic [1:0] CFG_COL_X = 2'd0;
  localparam logic [1:0] CFG_COL_Y = 2'd1;
  localparam logic [1:0] CFG_COL_Z = 2'd2;
  localparam logic [1:0] CFG_DIST  = 2'd3;

  localparam logic [47:0] RST_COL_X = 48'd16384;
  localparam logic [47:0] RST_COL_Y = 48'd1073741824;
  localparam logic [47:0] RST_COL_Z = 48'd70368744177664;

  localparam int QBITS = 21;   // quotient bits resolved by the divider
  localparam int RW    = 54;   // divider remainder width

  localparam logic signed [32:0] NEAR_Q14 = 33'sd1638400;
  localparam logic signed [19:0] SX_MAX   = 20'sd524287;
  localparam logic signed [19:0] SX_MIN   = -20'sd524288;
  localparam logic signed [31:0] DEP_MAX  = 32'sd8388607;
  localparam logic signed [31:0] DEP_MIN  = -32'sd8388608;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [31:0]      den;
    logic [QBITS-1:0] q;
    logic             neg;
    logic             ovf;
  } dlane_t;

  // one restoring division step at quotient bit b
  function automatic dlane_t div_step(dlane_t a, int b);
    dlane_t        r;
    logic [RW-1:0] dsh;
    r   = a;
    dsh = {{(RW-32){1'b0}}, a.den} << b;
    if (a.rem >= dsh) begin
      r.rem  = a.rem - dsh;
      r.q[b] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/vertex_transform_project.sv -----
// Vertex rotate, perspective divide and screen mapping pipeline.
// Depends on vtp_pkg.
// Accepts one word per cycle while the output word is not waiting.
// The 21-stage restoring divider resolves one quotient bit a stage.
// The whole pipeline advances together and holds when the output word waits.
// Synchronous reset clears valid bits and loads the identity matrix, distance 0.
module vertex_transform_project (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vtp_pkg::vtx_t    in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output vtp_pkg::scr_t    out_word,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [47:0]      cfg_data
);

  logic [47:0]        col_x, col_y, col_z;
  logic signed [23:0] view_dist;
  logic               en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_x     <= vtp_pkg::RST_COL_X;
      col_y     <= vtp_pkg::RST_COL_Y;
      col_z     <= vtp_pkg::RST_COL_Z;
      view_dist <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vtp_pkg::CFG_COL_X: col_x <= cfg_data;
        vtp_pkg::CFG_COL_Y: col_y <= cfg_data;
        vtp_pkg::CFG_COL_Z: col_z <= cfg_data;
        vtp_pkg::CFG_DIST:  view_dist <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // stage 1: nine products
  logic               v1;
  logic signed [23:0] px [0:2][0:2];
  logic signed [23:0] view_dist1;
  logic signed [7:0]  vin [0:2];
  logic [47:0]        cols [0:2];

  assign vin[0] = in_word.vertex_x;
  assign vin[1] = in_word.vertex_y;
  assign vin[2] = in_word.vertex_z;
  assign cols[0] = col_x;
  assign cols[1] = col_y;
  assign cols[2] = col_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          px[c][j] <= vin[j] * $signed(cols[c][16*j +: 16]);
        end
      end
      view_dist1 <= view_dist;
    end
  end

  // stage 2: column sums, with the view distance added to z
  logic               v2;
  logic signed [25:0] rx2, ry2;
  logic signed [31:0] rz2;

  always_ff @(posedge clk) begin
    if (en) begin
      rx2 <= 26'(px[0][0]) + 26'(px[0][1]) + 26'(px[0][2]);
      ry2 <= 26'(px[1][0]) + 26'(px[1][1]) + 26'(px[1][2]);
      rz2 <= 32'(px[2][0]) + 32'(px[2][1]) + 32'(px[2][2])
             + 32'($signed({view_dist1, 6'b0}));
    end
  end

  // stage 3: denominator, depth, numerators
  logic               v3;
  logic signed [32:0] den3;
  logic signed [45:0] nx3, ny3;
  logic signed [23:0] dep3;
  logic signed [32:0] den_c;
  logic signed [33:0] tx;
  logic signed [31:0] dq;

  always_comb begin
    den_c = 33'(rz2) + vtp_pkg::NEAR_Q14;
    tx    = 34'(den_c) + 34'(rx2);
    dq    = rz2 / 32'sd64;
  end

  // x: 3840*(den + rx); y: 2176*den + 3840*ry
  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= den_c;
      nx3  <= (46'(tx) <<< 12) - (46'(tx) <<< 8);
      ny3  <= (46'(den_c) <<< 11) + (46'(den_c) <<< 7)
              + (46'(ry2) <<< 12) - (46'(ry2) <<< 8);
      if (dq > vtp_pkg::DEP_MAX)      dep3 <= vtp_pkg::DEP_MAX[23:0];
      else if (dq < vtp_pkg::DEP_MIN) dep3 <= vtp_pkg::DEP_MIN[23:0];
      else                            dep3 <= dq[23:0];
    end
  end

  // stage 4 onward: sign split, range check, then one quotient bit a stage
  vtp_pkg::dlane_t    dx [0:vtp_pkg::QBITS];
  vtp_pkg::dlane_t    dy [0:vtp_pkg::QBITS];
  logic               vd [0:vtp_pkg::QBITS];
  logic               bh [0:vtp_pkg::QBITS];
  logic signed [23:0] dp [0:vtp_pkg::QBITS];
  logic               beh3;
  logic [45:0]        ax, ay;
  logic [vtp_pkg::RW-1:0] dlim;

  always_comb begin
    beh3 = (den3 <= 33'sd0);
    ax   = nx3[45] ? 46'(-nx3) : 46'(nx3);
    ay   = ny3[45] ? 46'(-ny3) : 46'(ny3);
    dlim = {{(vtp_pkg::RW-32){1'b0}}, den3[31:0]} << vtp_pkg::QBITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx[0].rem <= vtp_pkg::RW'(ax);
      dx[0].den <= den3[31:0];
      dx[0].q   <= '0;
      dx[0].neg <= nx3[45];
      dx[0].ovf <= vtp_pkg::RW'(ax) >= dlim;
      dy[0].rem <= vtp_pkg::RW'(ay);
      dy[0].den <= den3[31:0];
      dy[0].q   <= '0;
      dy[0].neg <= ny3[45];
      dy[0].ovf <= vtp_pkg::RW'(ay) >= dlim;
      bh[0]     <= beh3;
      dp[0]     <= dep3;
      for (int k = 0; k < vtp_pkg::QBITS; k++) begin
        dx[k+1] <= vtp_pkg::div_step(dx[k], vtp_pkg::QBITS - 1 - k);
        dy[k+1] <= vtp_pkg::div_step(dy[k], vtp_pkg::QBITS - 1 - k);
        bh[k+1] <= bh[k];
        dp[k+1] <= dp[k];
      end
    end
  end

  function automatic logic signed [19:0] sat_q(vtp_pkg::dlane_t a);
    logic signed [20:0] nq;
    nq = -$signed({1'b0, a.q[19:0]});
    if (!a.neg) begin
      if (a.ovf || a.q > 21'd524287) return vtp_pkg::SX_MAX;
      return $signed(a.q[19:0]);
    end
    if (a.ovf || a.q > 21'd524288) return vtp_pkg::SX_MIN;
    return nq[19:0];
  endfunction

  // output word register
  always_ff @(posedge clk) begin
    if (en) begin
      out_word.depth         <= dp[vtp_pkg::QBITS];
      out_word.behind_viewer <= bh[vtp_pkg::QBITS];
      out_word.screen_x      <= bh[vtp_pkg::QBITS] ? 20'sd0 : sat_q(dx[vtp_pkg::QBITS]);
      out_word.screen_y      <= bh[vtp_pkg::QBITS] ? 20'sd0 : sat_q(dy[vtp_pkg::QBITS]);
    end
  end

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= vtp_pkg::QBITS; k++) vd[k] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      vd[0] <= v3;
      for (int k = 0; k < vtp_pkg::QBITS; k++) vd[k+1] <= vd[k];
      out_valid <= vd[vtp_pkg::QBITS];
    end
  end

endmodule
